FILE: src/two_stage_shelf_tone_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shelf tone filter
// Shared helpers that wrap concurrent assertions on clk with arst_n disable.
// ----------------------------------------------------------------------------
`ifndef TWO_STAGE_SHELF_TONE_FILTER_CORE_MACROS_SVH
`define TWO_STAGE_SHELF_TONE_FILTER_CORE_MACROS_SVH

// ante implies cons in the same cycle
`define TSSTF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define TSSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tsstf_pkg.sv
// ----------------------------------------------------------------------------
// Shelf tone filter package
// Shared constants, register indexes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package tsstf_pkg;

	localparam int MANT_DEFAULT = 28;
	localparam int COEF_W       = 32;
	localparam int SAMPLE_W     = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int NUM_COEF     = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_B0   = 3'd0,
		REG_LOW_B1   = 3'd1,
		REG_LOW_A1M  = 3'd2,
		REG_HIGH_B0  = 3'd3,
		REG_HIGH_B1  = 3'd4,
		REG_HIGH_A1M = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_LOW_B0,
		OP_LOW_B1,
		OP_LOW_A1M,
		OP_HIGH_B0,
		OP_HIGH_B1,
		OP_HIGH_A1M
	} op_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ML0,
		ST_ML1,
		ST_ML2,
		ST_MH1,
		ST_MH2,
		ST_MH0,
		ST_ADDH,
		ST_SAT
	} ctrl_state_t;

	typedef struct packed {
		logic    load_in;
		logic    mul_en;
		op_sel_t op_sel;
		logic    low_add;
		logic    high_add;
		logic    low_upd;
		logic    sat_wr;
	} dp_cmd_t;

endpackage

FILE: src/tsstf_if.sv
// ----------------------------------------------------------------------------
// Shelf tone filter channel interfaces
// Sample input, filtered output and coefficient write channels.
// ----------------------------------------------------------------------------
interface tsstf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [tsstf_pkg::SAMPLE_W-1:0] audio_in;

	modport source (output valid, output audio_in, input ready);
	modport sink (input valid, input audio_in, output ready);
endinterface

interface tsstf_out_if #(
	parameter int W = tsstf_pkg::MANT_DEFAULT + 1
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] audio_out;

	modport source (output valid, output audio_out, input ready);
	modport sink (input valid, input audio_out, output ready);
endinterface

interface tsstf_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [tsstf_pkg::CFG_IDX_W-1:0]      index;
	logic [tsstf_pkg::COEF_W-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/tsstf_ctrl.sv
// ----------------------------------------------------------------------------
// Shelf tone filter controller
// Sequences the six shared multiplies, accumulation, saturation and handoff.
// ----------------------------------------------------------------------------
`include "two_stage_shelf_tone_filter_core_macros.svh"

module tsstf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output tsstf_pkg::dp_cmd_t  cmd
);

	tsstf_pkg::ctrl_state_t state_q;
	tsstf_pkg::ctrl_state_t state_d;
	logic                   out_valid_q;
	logic                   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == tsstf_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsstf_pkg::ST_IDLE: begin
				if (in_valid) state_d = tsstf_pkg::ST_ML0;
			end
			tsstf_pkg::ST_ML0:  state_d = tsstf_pkg::ST_ML1;
			tsstf_pkg::ST_ML1:  state_d = tsstf_pkg::ST_ML2;
			tsstf_pkg::ST_ML2:  state_d = tsstf_pkg::ST_MH1;
			tsstf_pkg::ST_MH1:  state_d = tsstf_pkg::ST_MH2;
			tsstf_pkg::ST_MH2:  state_d = tsstf_pkg::ST_MH0;
			tsstf_pkg::ST_MH0:  state_d = tsstf_pkg::ST_ADDH;
			tsstf_pkg::ST_ADDH: state_d = tsstf_pkg::ST_SAT;
			tsstf_pkg::ST_SAT: begin
				if (out_free) state_d = tsstf_pkg::ST_IDLE;
			end
			default:            state_d = tsstf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.op_sel   = tsstf_pkg::OP_LOW_B0;
		cmd.load_in  = in_valid && (state_q == tsstf_pkg::ST_IDLE);
		unique case (state_q)
			tsstf_pkg::ST_IDLE: begin
			end
			tsstf_pkg::ST_ML0: begin
				cmd.mul_en = 1'b1;
				cmd.op_sel = tsstf_pkg::OP_LOW_B0;
			end
			tsstf_pkg::ST_ML1: begin
				cmd.mul_en  = 1'b1;
				cmd.op_sel  = tsstf_pkg::OP_LOW_B1;
				cmd.low_add = 1'b1;
			end
			tsstf_pkg::ST_ML2: begin
				cmd.mul_en  = 1'b1;
				cmd.op_sel  = tsstf_pkg::OP_LOW_A1M;
				cmd.low_add = 1'b1;
			end
			tsstf_pkg::ST_MH1: begin
				cmd.mul_en  = 1'b1;
				cmd.op_sel  = tsstf_pkg::OP_HIGH_B1;
				cmd.low_add = 1'b1;
			end
			tsstf_pkg::ST_MH2: begin
				cmd.mul_en   = 1'b1;
				cmd.op_sel   = tsstf_pkg::OP_HIGH_A1M;
				cmd.high_add = 1'b1;
				cmd.low_upd  = 1'b1;
			end
			tsstf_pkg::ST_MH0: begin
				cmd.mul_en   = 1'b1;
				cmd.op_sel   = tsstf_pkg::OP_HIGH_B0;
				cmd.high_add = 1'b1;
			end
			tsstf_pkg::ST_ADDH: begin
				cmd.high_add = 1'b1;
			end
			tsstf_pkg::ST_SAT: begin
				cmd.sat_wr = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsstf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.sat_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TSSTF_ASSERT_SAME(a_word_from_sat, $rose(out_valid_q), $past(state_q == tsstf_pkg::ST_SAT), "result word raised outside saturation step")
	`TSSTF_ASSERT_NEXT(a_hold_on_stall, (state_q == tsstf_pkg::ST_SAT) && out_valid_q && !out_ready, state_q == tsstf_pkg::ST_SAT, "left saturation step while output stalled")
	`TSSTF_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == tsstf_pkg::ST_ML0, "accepted word did not start the multiply sequence")
	`TSSTF_ASSERT_SAME(a_one_acc_add, cmd.low_add || cmd.high_add, !(cmd.low_add && cmd.high_add), "both accumulators added in one cycle")

endmodule

FILE: src/tsstf_datapath.sv
// ----------------------------------------------------------------------------
// Shelf tone filter datapath
// Coefficients, filter state, shared 32x32 multiplier and two accumulators.
// ----------------------------------------------------------------------------
module tsstf_datapath #(
	parameter int MANT = tsstf_pkg::MANT_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tsstf_pkg::dp_cmd_t                   cmd,
	input  logic signed [tsstf_pkg::SAMPLE_W-1:0] audio_in,
	input  logic                                 cfg_wr,
	input  logic [tsstf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsstf_pkg::COEF_W-1:0]         cfg_data,
	output logic signed [MANT:0]                 audio_out
);

	localparam int CW = tsstf_pkg::COEF_W;
	localparam int SW = tsstf_pkg::SAMPLE_W;
	localparam int AW = 2 * CW;
	localparam logic signed [CW-1:0] CoefUnity = CW'(64'sd1 <<< MANT);
	localparam logic signed [AW-1:0] SatPos    = (64'sd1 <<< (2 * MANT)) - 64'sd1;
	localparam logic signed [AW-1:0] SatNeg    = -SatPos;

	logic signed [CW-1:0]   coef_q [tsstf_pkg::NUM_COEF];
	logic signed [MANT-1:0] x_q;
	logic signed [MANT-1:0] low_prev_in_q;
	logic signed [SW-1:0]   low_prev_out_q;
	logic signed [AW-1:0]   low_accum_q;
	logic signed [SW-1:0]   high_prev_in_q;
	logic signed [MANT:0]   high_prev_out_q;
	logic signed [AW-1:0]   high_accum_q;
	logic signed [AW-1:0]   prod_q;
	logic signed [MANT:0]   audio_out_q;

	logic signed [CW-1:0]   coef_sel;
	logic signed [SW-1:0]   opnd_sel;
	logic signed [AW-1:0]   prod_d;
	logic signed [SW-1:0]   y_low;
	logic signed [AW-1:0]   sat_acc;

	assign y_low = low_accum_q[MANT+SW-1:MANT];

	always_comb begin
		unique case (cmd.op_sel)
			tsstf_pkg::OP_LOW_B0: begin
				coef_sel = coef_q[tsstf_pkg::REG_LOW_B0];
				opnd_sel = {{(SW-MANT){x_q[MANT-1]}}, x_q};
			end
			tsstf_pkg::OP_LOW_B1: begin
				coef_sel = coef_q[tsstf_pkg::REG_LOW_B1];
				opnd_sel = {{(SW-MANT){low_prev_in_q[MANT-1]}}, low_prev_in_q};
			end
			tsstf_pkg::OP_LOW_A1M: begin
				coef_sel = coef_q[tsstf_pkg::REG_LOW_A1M];
				opnd_sel = low_prev_out_q;
			end
			tsstf_pkg::OP_HIGH_B0: begin
				coef_sel = coef_q[tsstf_pkg::REG_HIGH_B0];
				opnd_sel = y_low;
			end
			tsstf_pkg::OP_HIGH_B1: begin
				coef_sel = coef_q[tsstf_pkg::REG_HIGH_B1];
				opnd_sel = high_prev_in_q;
			end
			tsstf_pkg::OP_HIGH_A1M: begin
				coef_sel = coef_q[tsstf_pkg::REG_HIGH_A1M];
				opnd_sel = {{(SW-MANT-1){high_prev_out_q[MANT]}}, high_prev_out_q};
			end
			default: begin
				coef_sel = '0;
				opnd_sel = '0;
			end
		endcase
	end

	assign prod_d = AW'(coef_sel) * AW'(opnd_sel);

	always_comb begin
		priority if (high_accum_q >= SatPos) begin
			sat_acc = SatPos;
		end else if (high_accum_q < SatNeg) begin
			sat_acc = SatNeg;
		end else begin
			sat_acc = high_accum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[tsstf_pkg::REG_LOW_B0]   <= CoefUnity;
			coef_q[tsstf_pkg::REG_LOW_B1]   <= '0;
			coef_q[tsstf_pkg::REG_LOW_A1M]  <= -CoefUnity;
			coef_q[tsstf_pkg::REG_HIGH_B0]  <= CoefUnity;
			coef_q[tsstf_pkg::REG_HIGH_B1]  <= '0;
			coef_q[tsstf_pkg::REG_HIGH_A1M] <= -CoefUnity;
		end else if (cfg_wr && (cfg_index <= tsstf_pkg::REG_HIGH_A1M)) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_prev_in_q   <= '0;
			low_prev_out_q  <= '0;
			low_accum_q     <= '0;
			high_prev_in_q  <= '0;
			high_prev_out_q <= '0;
			high_accum_q    <= '0;
		end else begin
			if (cmd.low_add) low_accum_q <= low_accum_q + prod_q;
			if (cmd.low_upd) begin
				low_prev_in_q  <= x_q;
				low_prev_out_q <= y_low;
			end
			if (cmd.high_add) begin
				high_accum_q <= high_accum_q + prod_q;
			end else if (cmd.sat_wr) begin
				high_accum_q    <= sat_acc;
				high_prev_in_q  <= y_low;
				high_prev_out_q <= sat_acc[2*MANT:MANT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) x_q <= audio_in[SW-1:SW-MANT];
		if (cmd.mul_en)  prod_q <= prod_d;
		if (cmd.sat_wr)  audio_out_q <= sat_acc[2*MANT:MANT];
	end

	assign audio_out = audio_out_q;

endmodule

FILE: src/two_stage_shelf_tone_filter_core.sv
// ----------------------------------------------------------------------------
// Two-stage shelf tone filter core
// Low shelf then high shelf first-order IIR with error feedback.
//
// Channels: sample (sink) takes one 32-bit left-justified audio word,
// result (source) gives one MANT+1 bit filtered word per sample, cfg (sink)
// writes one of six Q-MANT coefficients by index; it is always ready and
// indexes above five are dropped. Write cfg only while the core is idle.
// A sample is taken only in the idle state. Its six products run through
// one shared 32x32 multiplier, one per cycle, each added to its section
// accumulator in the next cycle; a final step saturates the high shelf sum.
// The result word is registered as the saturation step ends; the next
// sample is taken once the controller is back in idle, not before. The
// result sits in an output register; while it is stalled the next sample
// is still processed, then held in the saturation step until the register
// frees. Reset clears all filter state, loads the passthrough coefficients
// and drops any pending result.
// ----------------------------------------------------------------------------
module two_stage_shelf_tone_filter_core #(
	parameter int MANT = tsstf_pkg::MANT_DEFAULT
) (
	input logic              clk,
	input logic              arst_n,
	tsstf_in_if.sink         sample,
	tsstf_out_if.source      result,
	tsstf_cfg_if.sink        cfg
);

	tsstf_pkg::dp_cmd_t  cmd;
	logic signed [MANT:0] audio_out;

	assign cfg.ready = 1'b1;

	tsstf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	tsstf_datapath #(
		.MANT (MANT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.audio_in  (sample.audio_in),
		.cfg_wr    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.audio_out (audio_out)
	);

	assign result.audio_out = audio_out;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shelf tone filter core testbench
// Streams audio words through the low and high shelf cascade under several
// coefficient sets. Directed words hit the sample extremes, the wrap of the
// low section and the clamp of the high section. Random words follow, with
// random gaps on both channels, a long output stall and a back-to-back
// stretch. Each output word is checked against a cycle-free model of the
// cascade that keeps its own accumulators.
// ----------------------------------------------------------------------------
module testbench;
	import tsstf_pkg::*;

	localparam int MANT = MANT_DEFAULT;
	localparam int OUT_W = MANT + 1;
	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 250000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint UNITY = longint'(1) << MANT;
	localparam longint CLAMP_POS = (longint'(1) << (2 * MANT)) - 1;
	localparam logic [COEF_W-1:0] EDGE_COEF [5] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h1000_0000, 32'hF000_0000
	};

	typedef logic signed [OUT_W-1:0] tone_word_t;
	typedef enum {SET_TAME, SET_WILD, SET_EDGE} coef_mix_t;

	logic clk;
	logic arst_n;

	tsstf_in_if                  sample_ch ();
	tsstf_out_if #(.W(OUT_W))    result_ch ();
	tsstf_cfg_if                 cfg_ch ();

	two_stage_shelf_tone_filter_core #(
		.MANT(MANT)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	longint coef_q [NUM_COEF];
	longint low_prev_in, low_prev_out, low_acc;
	longint high_prev_in, high_prev_out, high_acc;

	tone_word_t tone_expected [$];
	int fail_count;
	int samples_sent;
	int words_checked;
	int coef_writes;
	int cycle_count;
	int hold_left;
	bit idle_on;

	always #HALF_PERIOD clk = ~clk;

	function automatic tone_word_t filter_sample(input logic signed [SAMPLE_W-1:0] audio);
		longint x;
		longint sum;
		longint y_low;
		longint acc;
		longint y_high;
		logic signed [31:0] y_low32;
		x = longint'(audio) >>> (SAMPLE_W - MANT);
		sum = low_acc + coef_q[REG_LOW_B0] * x + coef_q[REG_LOW_B1] * low_prev_in
			+ coef_q[REG_LOW_A1M] * low_prev_out;
		low_acc = sum;
		y_low32 = 32'(sum >>> MANT);
		y_low = longint'(y_low32);
		low_prev_in = x;
		low_prev_out = y_low;
		sum = high_acc + coef_q[REG_HIGH_B0] * y_low + coef_q[REG_HIGH_B1] * high_prev_in
			+ coef_q[REG_HIGH_A1M] * high_prev_out;
		if (sum >= CLAMP_POS) begin
			acc = CLAMP_POS;
		end else if (sum < -CLAMP_POS) begin
			acc = -CLAMP_POS;
		end else begin
			acc = sum;
		end
		high_acc = acc;
		y_high = acc >>> MANT;
		high_prev_in = y_low;
		high_prev_out = y_high;
		return y_high[OUT_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic signed [SAMPLE_W-1:0] audio;
		case ($urandom_range(7))
			4: audio = (int'($urandom_range(65535)) - 32768) <<< 4;
			5: audio = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			6: audio = $urandom & 32'h0000_000F;
			7: audio = (int'($urandom_range(1 << 20)) - (1 << 19)) <<< 8;
			default: audio = $urandom;
		endcase
		return audio;
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef(input coef_mix_t mix,
		input logic [CFG_IDX_W-1:0] idx);
		int v;
		case (mix)
			SET_TAME: begin
				if (idx == REG_LOW_B0 || idx == REG_HIGH_B0) begin
					v = $urandom_range(1 << 29, 1 << 27);
				end else if (idx == REG_LOW_B1 || idx == REG_HIGH_B1) begin
					v = -int'($urandom_range(1 << 28));
				end else begin
					v = -int'($urandom_range(1 << 28, 1 << 22));
				end
			end
			SET_WILD: v = $urandom;
			default: v = EDGE_COEF[$urandom_range(4)];
		endcase
		return v;
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] audio);
		while (idle_on && $urandom_range(99) < 37) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.audio_in <= audio;
		do @(posedge clk); while (!sample_ch.ready);
		tone_expected.push_back(filter_sample(audio));
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (tone_expected.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx < NUM_COEF) coef_q[idx] = longint'($signed(value));
		coef_writes++;
		@(negedge clk);
	endtask

	task automatic load_coef_set(input coef_mix_t mix);
		wait_drained();
		write_coef(REG_LOW_B0, pick_coef(mix, REG_LOW_B0));
		write_coef(REG_LOW_B1, pick_coef(mix, REG_LOW_B1));
		write_coef(REG_LOW_A1M, pick_coef(mix, REG_LOW_A1M));
		write_coef(REG_HIGH_B0, pick_coef(mix, REG_HIGH_B0));
		write_coef(REG_HIGH_B1, pick_coef(mix, REG_HIGH_B1));
		write_coef(REG_HIGH_A1M, pick_coef(mix, REG_HIGH_A1M));
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_passthrough();
		send_sample(32'sh0000_0000);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_sample(32'shFFFF_FFFF);
		send_sample(32'sh0000_0001);
		send_sample(32'sh0000_0010);
		send_sample(32'shFFFF_FFF0);
		send_sample(32'shAAAA_AAAA);
		send_sample(32'sh5555_5555);
		wait_drained();
	endtask

	task automatic test_wrap_and_clamp();
		write_coef(REG_LOW_B0, 32'h7FFF_FFFF);
		write_coef(REG_LOW_B1, 32'h7FFF_FFFF);
		write_coef(REG_LOW_A1M, 32'h7FFF_FFFF);
		write_coef(REG_HIGH_B0, 32'h7FFF_FFFF);
		write_coef(REG_HIGH_B1, 32'h7FFF_FFFF);
		write_coef(REG_HIGH_A1M, 32'h7FFF_FFFF);
		write_coef(REG_SPARE_LO, 32'h1234_5678);
		write_coef(REG_SPARE_HI, 32'hFFFF_FFFF);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		repeat (5) send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		wait_drained();
		write_coef(REG_LOW_B0, 32'h8000_0000);
		write_coef(REG_LOW_B1, 32'h8000_0000);
		write_coef(REG_LOW_A1M, 32'h8000_0000);
		write_coef(REG_HIGH_B0, 32'h8000_0000);
		write_coef(REG_HIGH_B1, 32'h8000_0000);
		write_coef(REG_HIGH_A1M, 32'h0000_0000);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		repeat (4) send_sample(32'sh8000_0000);
		repeat (4) send_sample(32'sh7FFF_FFFF);
		wait_drained();
	endtask

	task automatic test_random_settings();
		coef_mix_t mix;
		for (int phase = 0; phase < 6; phase++) begin
			mix = (phase % 3 == 0) ? SET_TAME : (phase % 3 == 1) ? SET_EDGE : SET_WILD;
			if (phase == 5) mix = SET_TAME;
			load_coef_set(mix);
			repeat (55) send_sample(pick_sample());
		end
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		load_coef_set(SET_TAME);
		hold_left = 300;
		repeat (40) send_sample(pick_sample());
		wait_drained();
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (50) send_sample(pick_sample());
		wait_drained();
		idle_on = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else if (!idle_on) begin
			result_ch.ready <= 1'b1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		tone_word_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (tone_expected.size() == 0) begin
				$error("audio_out: unexpected word %0d", result_ch.audio_out);
				fail_count++;
			end else begin
				want = tone_expected.pop_front();
				words_checked++;
				if (result_ch.audio_out !== want) begin
					$error("audio_out mismatch: expected %0d, actual %0d",
						want, result_ch.audio_out);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d words outstanding", tone_expected.size());
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.audio_in = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		fail_count = 0;
		samples_sent = 0;
		words_checked = 0;
		coef_writes = 0;
		cycle_count = 0;
		hold_left = 0;
		idle_on = 1'b1;
		coef_q[REG_LOW_B0] = UNITY;
		coef_q[REG_LOW_B1] = 0;
		coef_q[REG_LOW_A1M] = -UNITY;
		coef_q[REG_HIGH_B0] = UNITY;
		coef_q[REG_HIGH_B1] = 0;
		coef_q[REG_HIGH_A1M] = -UNITY;
		low_prev_in = 0;
		low_prev_out = 0;
		low_acc = 0;
		high_prev_in = 0;
		high_prev_out = 0;
		high_acc = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_passthrough();
		test_wrap_and_clamp();
		test_random_settings();
		test_output_backpressure();
		test_back_to_back();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d samples and checked %0d filtered words", samples_sent,
			words_checked);
		$display("across %0d coefficient writes, incl. wrap, clamp and stalls", coef_writes);
		if (fail_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
